/* design/bbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Sizes of the opener stack and line counter, character codes, result types.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LINE_BITS   = 16;
    localparam int PTR_BITS    = $clog2(STACK_DEPTH);
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_BITS  = 2 + LINE_BITS;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISSING  = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_HALTED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BR_ROUND  = 2'd0,
        BR_SQUARE = 2'd1,
        BR_CURLY  = 2'd2,
        BR_ANGLE  = 2'd3
    } t_bracket;

    typedef struct packed {
        logic     hit;
        t_bracket kind;
    } t_code;

    typedef struct packed {
        t_status     status;
        logic [7:0]  missing_symbol;
        logic [15:0] error_line;
        logic [6:0]  nesting_depth;
    } t_result;

    typedef struct packed {
        logic                  wr_en;
        logic [PTR_BITS-1:0]   wr_addr;
        logic [ENTRY_BITS-1:0] wr_data;
        logic [PTR_BITS-1:0]   rd_addr;
    } t_ram_req;

    function automatic t_code opener_code(input logic [7:0] ch);
        t_code c;
        c.hit  = 1'b1;
        c.kind = BR_ROUND;
        case (ch)
            CH_LPAREN: c.kind = BR_ROUND;
            CH_LBRACK: c.kind = BR_SQUARE;
            CH_LBRACE: c.kind = BR_CURLY;
            CH_LANGLE: c.kind = BR_ANGLE;
            default:   c.hit  = 1'b0;
        endcase
        return c;
    endfunction

    function automatic t_code closer_code(input logic [7:0] ch);
        t_code c;
        c.hit  = 1'b1;
        c.kind = BR_ROUND;
        case (ch)
            CH_RPAREN: c.kind = BR_ROUND;
            CH_RBRACK: c.kind = BR_SQUARE;
            CH_RBRACE: c.kind = BR_CURLY;
            CH_RANGLE: c.kind = BR_ANGLE;
            default:   c.hit  = 1'b0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] opener_char(input t_bracket kind);
        logic [7:0] ch;
        case (kind)
            BR_ROUND:  ch = CH_LPAREN;
            BR_SQUARE: ch = CH_LBRACK;
            BR_CURLY:  ch = CH_LBRACE;
            BR_ANGLE:  ch = CH_LANGLE;
            default:   ch = CH_LPAREN;
        endcase
        return ch;
    endfunction

endpackage

/* design/bracket_balance_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit: streaming bracket balance checker
// Checks ( [ { < against ) ] } > one character per transfer, tracks line
// numbers and reports the first imbalance, then halts until reset.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  input    in         i_valid / o_stall    i_ch
//  result   out        o_valid / i_stall    o_status, o_missing_symbol,
//                                           o_error_line, o_nesting_depth
//
// One character per cycle sustained while the result side does not stall;
// each result passes through the input register, then the result register,
// before it can transfer.
// The stack top is prefetched from the opener RAM each cycle, with a bypass
// for the entry pushed on the previous cycle, so a pop never waits.
// Reset (i_rst_n low, synchronous) empties the stack, sets the line to 1 and
// clears the halted flag; the stack RAM needs no clearing.
// A stall on the result side holds the result register and backs up into
// o_stall only once the input register is also full.
//
module bracket_balance_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_missing_symbol,
    output logic [15:0] o_error_line,
    output logic [6:0]  o_nesting_depth
);

    logic              r_in_valid;
    logic [7:0]        r_ch;
    logic              r_out_valid;
    bbc_pkg::t_result  r_out;

    logic              out_free;
    logic              fire;
    logic              in_take;

    bbc_pkg::t_ram_req             ram_req;
    logic [bbc_pkg::ENTRY_BITS-1:0] ram_rd_data;
    bbc_pkg::t_result              result;

    // Advance the held character when the result register is empty or its
    // transfer completes this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !fire;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch <= i_ch;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    bbc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_ch      (r_ch),
        .i_rd_data (ram_rd_data),
        .o_ram     (ram_req),
        .o_result  (result)
    );

    // Opener stack: code and line of each open bracket.
    bbc_ram #(
        .WIDTH (bbc_pkg::ENTRY_BITS),
        .DEPTH (bbc_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_missing_symbol = r_out.missing_symbol;
    assign o_error_line     = r_out.error_line;
    assign o_nesting_depth  = r_out.nesting_depth;

endmodule

/* design/bbc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/bbc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_core: bracket stack control and line counter
// Classifies one character, pushes or pops the opener stack, tracks the line
// number and the halted flag, and forms the result for that character.
// ----------------------------------------------------------------------------
module bbc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [7:0]                     i_ch,
    input  logic [bbc_pkg::ENTRY_BITS-1:0] i_rd_data,
    output bbc_pkg::t_ram_req              o_ram,
    output bbc_pkg::t_result               o_result
);

    logic [bbc_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic [bbc_pkg::LINE_BITS-1:0]  r_line, n_line;
    logic                           r_halted, n_halted;
    logic                           r_byp_valid, n_byp_valid;
    logic [bbc_pkg::ENTRY_BITS-1:0] r_byp_data;

    logic [bbc_pkg::LINE_BITS-1:0]  line_inc;
    logic [bbc_pkg::ENTRY_BITS-1:0] top;
    bbc_pkg::t_bracket              top_kind;
    logic [bbc_pkg::LINE_BITS-1:0]  top_line;
    bbc_pkg::t_code                 oc;
    bbc_pkg::t_code                 cc;
    logic                           push;
    logic [bbc_pkg::ENTRY_BITS-1:0] push_data;

    // The entry written last cycle is not yet visible on the RAM read port.
    assign top      = r_byp_valid ? r_byp_data : i_rd_data;
    assign top_kind = bbc_pkg::t_bracket'(top[bbc_pkg::ENTRY_BITS-1 -: 2]);
    assign top_line = top[bbc_pkg::LINE_BITS-1:0];

    assign oc = bbc_pkg::opener_code(i_ch);
    assign cc = bbc_pkg::closer_code(i_ch);

    assign line_inc = ((i_ch == bbc_pkg::CH_NL) && (r_line != bbc_pkg::LINE_MAX))
                      ? r_line + 1'b1 : r_line;
    assign push_data = {oc.kind, line_inc};

    always_comb begin
        n_count     = r_count;
        n_line      = r_line;
        n_halted    = r_halted;
        push        = 1'b0;
        o_result.status         = bbc_pkg::ST_OK;
        o_result.missing_symbol = 8'd0;
        o_result.error_line     = 16'd0;
        if (r_halted) begin
            o_result.status = bbc_pkg::ST_HALTED;
        end else begin
            n_line = line_inc;
            if (oc.hit) begin
                if (r_count == bbc_pkg::CNT_BITS'(bbc_pkg::STACK_DEPTH)) begin
                    o_result.status         = bbc_pkg::ST_OVERFLOW;
                    o_result.missing_symbol = i_ch;
                    o_result.error_line     = 16'(line_inc);
                    n_halted                = 1'b1;
                end else begin
                    push    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else if (cc.hit) begin
                if (r_count == '0) begin
                    o_result.status         = bbc_pkg::ST_MISSING;
                    o_result.missing_symbol = bbc_pkg::opener_char(cc.kind);
                    o_result.error_line     = 16'(line_inc);
                    n_halted                = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    if (top_kind != cc.kind) begin
                        o_result.status         = bbc_pkg::ST_MISMATCH;
                        o_result.missing_symbol = bbc_pkg::opener_char(top_kind);
                        o_result.error_line     = 16'(top_line);
                        n_halted                = 1'b1;
                    end
                end
            end
        end
        o_result.nesting_depth = 7'(n_count);

        // Hold all state unless this character is actually consumed.
        if (!i_fire) begin
            n_count  = r_count;
            n_line   = r_line;
            n_halted = r_halted;
            push     = 1'b0;
        end
        n_byp_valid = push;
    end

    // Read address tracks the top of the stack after this edge.
    assign o_ram.wr_en   = push;
    assign o_ram.wr_addr = r_count[bbc_pkg::PTR_BITS-1:0];
    assign o_ram.wr_data = push_data;
    assign o_ram.rd_addr = bbc_pkg::PTR_BITS'(n_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_line      <= bbc_pkg::LINE_BITS'(1);
            r_halted    <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_line      <= n_line;
            r_halted    <= n_halted;
            r_byp_valid <= n_byp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_byp_data <= push_data;
        end
    end

endmodule
